/* sv/wmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants of the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;   // holds any image size up to 4096
  localparam int ADDR_W_MAX = 12;   // column address of the widest line store
  localparam int SIDE       = 5;
  localparam int CELLS      = 25;
  localparam int RANK_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [RANK_W-1:0] MED9_RANK  = 5'd4;
  localparam logic [RANK_W-1:0] MED25_RANK = 5'd12;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd512;

  // one classified request handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]      pix;
    logic [ADDR_W_MAX-1:0] col;
    logic [DIM_W-1:0]      y;
    logic [DIM_W-1:0]      x;
    logic                  produce;
    logic                  frame_end;
  } item_t;

  // saturated frame geometry
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             r2;
  } geom_t;

endpackage

/* sv/wmf_front.sv */
// ----------------------------------------------------------------------------
// wmf_front
// Config registers, frame counters and request classification.
// ----------------------------------------------------------------------------
module wmf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wmf_pkg::PIX_W-1:0]     in_tdata,
  input  logic                          in_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output wmf_pkg::item_t                q_item,
  output wmf_pkg::geom_t                geom
);
  import wmf_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

  logic                  mode_r;
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIM_W-1:0]      col_r;
  logic [DIM_W-1:0]      ox_r;
  logic [DIM_W-1:0]      oy_r;

  logic [DIM_W-1:0]   w;
  logic [DIM_W-1:0]   h;
  logic               r2;
  logic [2*DIM_W-1:0] area;
  logic [CNT_W-1:0]   total;
  logic [DIM_W+1:0]   lag;
  logic               ok;
  logic               take;
  logic               produce;
  logic               frame_end;
  logic               cfg_hit;

  always_comb begin
    if (width_r == '0) w = DIM_W'(1);
    else if ({2'b00, width_r} > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = {2'b00, width_r};
    if (height_r == '0) h = DIM_W'(1);
    else if ({2'b00, height_r} > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = {2'b00, height_r};
  end

  assign r2    = mode_r && (MAX_WINDOW >= 5);
  assign area  = w * h;
  assign total = area[CNT_W-1:0];
  assign lag   = r2 ? ({1'b0, w, 1'b0} + (DIM_W+2)'(2)) : ({2'b00, w} + (DIM_W+2)'(1));

  // pixels only inside the frame, flushes only past its last pixel
  assign ok        = in_tuser ? (cnt_r >= total) : (cnt_r < total);
  assign in_tready = !q_full;
  assign take      = in_tvalid && !q_full && ok;
  assign produce   = cnt_r >= CNT_W'(lag);
  assign frame_end = produce && (oy_r == h - DIM_W'(1)) && (ox_r == w - DIM_W'(1));
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                                   cfg_index == REG_HEIGHT);

  assign q_push          = take;
  assign q_item.pix      = in_tuser ? '0 : in_tdata;
  assign q_item.col      = col_r[ADDR_W_MAX-1:0];
  assign q_item.y        = oy_r;
  assign q_item.x        = ox_r;
  assign q_item.produce  = produce;
  assign q_item.frame_end = frame_end;
  assign geom.w  = w;
  assign geom.h  = h;
  assign geom.r2 = r2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
      cnt_r    <= '0;
      col_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_WIDTH:  width_r  <= cfg_data;
        default:    height_r <= cfg_data;
      endcase
      cnt_r <= '0;
      col_r <= '0;
      ox_r  <= '0;
      oy_r  <= '0;
    end else if (take) begin
      if (frame_end) begin
        cnt_r <= '0;
        col_r <= '0;
        ox_r  <= '0;
        oy_r  <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        col_r <= (col_r + DIM_W'(1) >= w) ? '0 : col_r + DIM_W'(1);
        if (produce) begin
          if (ox_r + DIM_W'(1) >= w) begin
            ox_r <= '0;
            oy_r <= oy_r + DIM_W'(1);
          end else begin
            ox_r <= ox_r + DIM_W'(1);
          end
        end
      end
    end
  end

endmodule

/* sv/wmf_fifo.sv */
// ----------------------------------------------------------------------------
// wmf_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module wmf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wmf_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output wmf_pkg::item_t head
);
  import wmf_pkg::*;

  localparam int PW = $clog2(DEPTH);

  item_t              mem_r [DEPTH];
  logic [PW-1:0]      wp_r;
  logic [PW-1:0]      rp_r;
  logic [PW:0]        cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt_r == (PW+1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

/* sv/wmf_back.sv */
// ----------------------------------------------------------------------------
// wmf_back
// Line store, 5x5 window and pipelined rank selection of the median.
// ----------------------------------------------------------------------------
module wmf_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  wmf_pkg::item_t            q_head,
  output logic                      q_pop,
  input  wmf_pkg::geom_t            geom,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [wmf_pkg::PIX_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import wmf_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int DW1 = DIM_W + 1;

  // four previous lines side by side, one byte each
  logic [4*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [4*PIX_W-1:0] rd_r;
  logic [4*PIX_W-1:0] fwd_data_r;
  logic               fwd_r;

  logic  s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  item_t s1_item_r, s2_item_r, s3_item_r, s4_item_r;
  logic  s3_r2_r;

  logic [PIX_W-1:0] win_r [SIDE][SIDE];
  logic [PIX_W-1:0] colv [SIDE];
  logic [4*PIX_W-1:0] lines;
  logic [4*PIX_W-1:0] wr_data;

  logic [PIX_W-1:0]  vals [CELLS];
  logic [CELLS-1:0]  mask;
  logic [CELLS-1:0]  lt [CELLS];
  logic [PIX_W-1:0]  vals_r [CELLS];
  logic [CELLS-1:0]  mask_r;
  logic [CELLS-1:0]  lt_r [CELLS];
  logic [RANK_W-1:0] target;
  logic [CELLS-1:0]  sel;
  logic [CELLS-1:0]  sel_r;
  logic [PIX_W-1:0]  vals4_r [CELLS];
  logic [PIX_W-1:0]  med;

  logic             en;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  logic [DW1-1:0] rr;
  logic [DW1-1:0] yr;
  logic [DW1-1:0] xr;

  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && !q_empty;

  assign lines   = fwd_r ? fwd_data_r : rd_r;
  assign colv[0] = s1_item_r.pix;
  assign colv[1] = lines[PIX_W-1:0];
  assign colv[2] = lines[2*PIX_W-1:PIX_W];
  assign colv[3] = lines[3*PIX_W-1:2*PIX_W];
  assign colv[4] = lines[4*PIX_W-1:3*PIX_W];
  assign wr_data = {lines[3*PIX_W-1:0], s1_item_r.pix};

  always_ff @(posedge clk) begin
    if (q_pop) rd_r <= lb_mem[q_head.col[AW-1:0]];
    if (en && s1_v_r) lb_mem[s1_item_r.col[AW-1:0]] <= wr_data;
  end

  // window: column delay b, line delay a
  always_ff @(posedge clk) begin
    if (en && s1_v_r) begin
      for (int a = 0; a < SIDE; a++) begin
        for (int b = SIDE - 1; b > 0; b--) begin
          win_r[a][b] <= win_r[a][b-1];
        end
        win_r[a][0] <= colv[a];
      end
    end
  end

  // zero outside the image and outside the selected window
  assign rr = geom.r2 ? DW1'(2) : DW1'(1);
  assign yr = {1'b0, s2_item_r.y} + rr;
  assign xr = {1'b0, s2_item_r.x} + rr;

  always_comb begin
    for (int a = 0; a < SIDE; a++) begin
      for (int b = 0; b < SIDE; b++) begin
        mask[a*SIDE+b] = (DW1'(a) <= {rr[DW1-2:0], 1'b0}) && (DW1'(b) <= {rr[DW1-2:0], 1'b0});
        vals[a*SIDE+b] = (mask[a*SIDE+b] && DW1'(a) <= yr && yr < {1'b0, geom.h} + DW1'(a) &&
                          DW1'(b) <= xr && xr < {1'b0, geom.w} + DW1'(b))
                         ? win_r[a][b] : '0;
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      for (int j = 0; j < CELLS; j++) begin
        lt[i][j] = mask[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
      end
    end
  end

  assign target = s3_r2_r ? MED25_RANK : MED9_RANK;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      sel[i] = mask_r[i] && (RANK_W'($countones(lt_r[i])) == target);
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < CELLS; i++) begin
      med = med | (sel_r[i] ? vals4_r[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_pop) begin
        s1_item_r  <= q_head;
        fwd_r      <= s1_v_r && (q_head.col == s1_item_r.col);
        fwd_data_r <= wr_data;
      end
      s2_item_r <= s1_item_r;
      s3_item_r <= s2_item_r;
      s3_r2_r   <= geom.r2;
      vals_r    <= vals;
      mask_r    <= mask;
      lt_r      <= lt;
      s4_item_r <= s3_item_r;
      sel_r     <= sel;
      vals4_r   <= vals_r;
      out_data_r <= med;
      out_last_r <= s4_item_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r && s4_item_r.produce;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/window_median_filter_unit.sv */
// ----------------------------------------------------------------------------
// window_median_filter_unit
// Streaming 3x3 / 5x5 median filter over a raster of 8-bit pixels.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  in_      in   tdata[7:0] pixel, tuser req_type      in_tvalid/in_tready
//  out_     out  tdata[7:0] median_value, tlast end    out_tvalid/out_tready
//  cfg_     in   cfg_index register, cfg_data value    cfg_valid/cfg_ready
//
//  one request per cycle sustained while the output is not stalled; a result shows
//  on out_tvalid after queue pop with line store read, window shift, compare, rank, select
//  rst_n synchronous: config returns to 3x3, 512x512, counters to frame start
//  a 4-entry queue lets the input run on while the output is stalled
//  the line store is one read and one write port, used once per request
// ----------------------------------------------------------------------------
module window_median_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wmf_pkg::PIX_W-1:0]      in_tdata,   // [7:0] pixel
  input  logic                           in_tuser,   // [0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wmf_pkg::PIX_W-1:0]      out_tdata,  // [7:0] median_value
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wmf_pkg::*;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_item, q_head;
  geom_t geom;

  wmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_item(q_item), .geom(geom)
  );

  wmf_fifo #(.DEPTH(4)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_item(q_item), .pop(q_pop),
    .full(q_full), .empty(q_empty), .head(q_head)
  );

  wmf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .geom(geom),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

/* sv/wmf_checker.sv */
// ----------------------------------------------------------------------------
// wmf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module wmf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // queue is empty after reset, so requests are taken
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // config never backpressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> cfg_ready)
    else $error("config not ready");

endmodule

bind window_median_filter_unit wmf_checker u_wmf_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .cfg_ready(cfg_ready)
);
